FILE: sv/deqd_pkg.sv
// ----------------------------------------------------------------------------
// deqd_pkg
// Shared types, codes and a ring helper for the double-ended queue with delete.
// ----------------------------------------------------------------------------
package deqd_pkg;

   localparam int DEPTH = 16;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_DELETE     = 3'd4;
   localparam logic [2:0] OP_CLEAR      = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_EMPTY     = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   // how an incoming word is handled
   localparam logic [1:0] KIND_ONE = 2'd0;
   localparam logic [1:0] KIND_POP = 2'd1;
   localparam logic [1:0] KIND_DEL = 2'd2;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] removed_value;
      logic [4:0]         entry_count;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic pop_done;
      logic find;
      logic shift;
      logic finish_nf;
      logic finish_del;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       rsp_free;
      logic       match;
      logic       scan_idle;
   } stat_type;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [CW-1:0] k);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(k);
      if (sum >= (CW+1)'(DEPTH)) begin
         sum = sum - (CW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

endpackage

FILE: sv/deqd_dp.sv
// ----------------------------------------------------------------------------
// deqd_dp
// Datapath: entry memory, ring pointers, scan pipeline and result register.
// ----------------------------------------------------------------------------
module deqd_dp (
   input  logic              clock,
   input  logic              reset,
   input  deqd_pkg::req_type req_payload,
   input  deqd_pkg::cmd_type cmd,
   output deqd_pkg::stat_type stat,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output deqd_pkg::rsp_type rsp_payload
);

   logic [31:0] mem [deqd_pkg::DEPTH];

   logic [deqd_pkg::AW-1:0] front_ff, front_in;
   logic [deqd_pkg::CW-1:0] count_ff, count_in;
   logic [deqd_pkg::CW-1:0] ridx_ff, ridx_in;
   logic [deqd_pkg::CW-1:0] chk_idx_ff, chk_idx_in;
   logic                    chk_v_ff, chk_v_in;
   logic [31:0]             val_ff, val_in;
   logic [31:0]             rdata_ff;
   deqd_pkg::rsp_type       rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    we, re, rsp_load, full, empty, match, scan_idle, rsp_free;
   logic [deqd_pkg::AW-1:0] waddr, raddr, front_dec;
   logic [31:0]             wdata;
   logic [deqd_pkg::CW-1:0] count_inc, count_dec;

   assign full      = (count_ff == deqd_pkg::CW'(deqd_pkg::DEPTH));
   assign empty     = (count_ff == '0);
   assign match     = chk_v_ff && (rdata_ff == val_ff);
   assign scan_idle = (ridx_ff >= count_ff) && !chk_v_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign count_inc = count_ff + deqd_pkg::CW'(1);
   assign count_dec = count_ff - deqd_pkg::CW'(1);
   assign front_dec = (front_ff == '0) ? deqd_pkg::AW'(deqd_pkg::DEPTH - 1)
                                       : front_ff - deqd_pkg::AW'(1);

   always_comb begin
      stat.rsp_free  = rsp_free;
      stat.match     = match;
      stat.scan_idle = scan_idle;
      if (req_payload.operation == deqd_pkg::OP_DELETE) begin
         stat.kind = deqd_pkg::KIND_DEL;
      end else if (((req_payload.operation == deqd_pkg::OP_POP_FRONT) ||
                    (req_payload.operation == deqd_pkg::OP_POP_BACK)) && !empty) begin
         stat.kind = deqd_pkg::KIND_POP;
      end else begin
         stat.kind = deqd_pkg::KIND_ONE;
      end
   end

   always_comb begin
      front_in   = front_ff;
      count_in   = count_ff;
      ridx_in    = ridx_ff;
      chk_idx_in = chk_idx_ff;
      chk_v_in   = chk_v_ff;
      val_in     = val_ff;
      rsp_in     = rsp_ff;
      rsp_load   = 1'b0;
      we         = 1'b0;
      waddr      = '0;
      wdata      = req_payload.value;
      re         = 1'b0;
      raddr      = '0;

      if (cmd.accept) begin
         rsp_in.status        = deqd_pkg::ST_OK;
         rsp_in.removed_value = '0;
         rsp_in.entry_count   = 5'(count_ff);
         case (req_payload.operation)
            deqd_pkg::OP_PUSH_FRONT: begin
               rsp_load = 1'b1;
               if (full) begin
                  rsp_in.status = deqd_pkg::ST_FULL;
               end else begin
                  front_in           = front_dec;
                  we                 = 1'b1;
                  waddr              = front_dec;
                  count_in           = count_inc;
                  rsp_in.entry_count = 5'(count_inc);
               end
            end
            deqd_pkg::OP_PUSH_BACK: begin
               rsp_load = 1'b1;
               if (full) begin
                  rsp_in.status = deqd_pkg::ST_FULL;
               end else begin
                  we                 = 1'b1;
                  waddr              = deqd_pkg::slot_of(front_ff, count_ff);
                  count_in           = count_inc;
                  rsp_in.entry_count = 5'(count_inc);
               end
            end
            deqd_pkg::OP_POP_FRONT: begin
               if (empty) begin
                  rsp_load      = 1'b1;
                  rsp_in.status = deqd_pkg::ST_EMPTY;
               end else begin
                  re       = 1'b1;
                  raddr    = front_ff;
                  front_in = deqd_pkg::slot_of(front_ff, deqd_pkg::CW'(1));
                  count_in = count_dec;
               end
            end
            deqd_pkg::OP_POP_BACK: begin
               if (empty) begin
                  rsp_load      = 1'b1;
                  rsp_in.status = deqd_pkg::ST_EMPTY;
               end else begin
                  re       = 1'b1;
                  raddr    = deqd_pkg::slot_of(front_ff, count_dec);
                  count_in = count_dec;
               end
            end
            deqd_pkg::OP_DELETE: begin
               val_in   = req_payload.value;
               ridx_in  = '0;
               chk_v_in = 1'b0;
            end
            deqd_pkg::OP_CLEAR: begin
               rsp_load           = 1'b1;
               count_in           = '0;
               front_in           = '0;
               rsp_in.entry_count = '0;
            end
            default: begin
               rsp_load = 1'b1;
            end
         endcase
      end

      // scan pipeline: one read issued and one word checked per cycle, except when a match is found
      if ((cmd.find && !match) || cmd.shift) begin
         if (ridx_ff < count_ff) begin
            re         = 1'b1;
            raddr      = deqd_pkg::slot_of(front_ff, ridx_ff);
            ridx_in    = ridx_ff + deqd_pkg::CW'(1);
            chk_idx_in = ridx_ff;
            chk_v_in   = 1'b1;
         end else begin
            chk_v_in = 1'b0;
         end
      end
      if (cmd.find && match) begin
         ridx_in  = chk_idx_ff + deqd_pkg::CW'(1);
         chk_v_in = 1'b0;
      end
      if (cmd.shift && chk_v_ff) begin
         we    = 1'b1;
         waddr = deqd_pkg::slot_of(front_ff, chk_idx_ff - deqd_pkg::CW'(1));
         wdata = rdata_ff;
      end

      if (cmd.pop_done) begin
         rsp_load             = 1'b1;
         rsp_in.status        = deqd_pkg::ST_OK;
         rsp_in.removed_value = rdata_ff;
         rsp_in.entry_count   = 5'(count_ff);
      end
      if (cmd.finish_nf) begin
         rsp_load             = 1'b1;
         rsp_in.status        = deqd_pkg::ST_NOT_FOUND;
         rsp_in.removed_value = '0;
         rsp_in.entry_count   = 5'(count_ff);
      end
      if (cmd.finish_del) begin
         rsp_load             = 1'b1;
         count_in             = count_dec;
         rsp_in.status        = deqd_pkg::ST_OK;
         rsp_in.removed_value = val_ff;
         rsp_in.entry_count   = 5'(count_dec);
      end

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         chk_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         chk_v_ff     <= chk_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ridx_ff    <= ridx_in;
      chk_idx_ff <= chk_idx_in;
      val_ff     <= val_in;
      rsp_ff     <= rsp_in;
   end

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: sv/deqd_ctrl.sv
// ----------------------------------------------------------------------------
// deqd_ctrl
// Controller: sequences ops done from idle, pops, and delete search and shift.
// ----------------------------------------------------------------------------
module deqd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  deqd_pkg::stat_type stat,
   output deqd_pkg::cmd_type  cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_POP   = 2'd1;
   localparam logic [1:0] S_FIND  = 2'd2;
   localparam logic [1:0] S_SHIFT = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = stat.rsp_free;
            if (req_valid && stat.rsp_free) begin
               cmd.accept = 1'b1;
               case (stat.kind)
                  deqd_pkg::KIND_POP: state_in = S_POP;
                  deqd_pkg::KIND_DEL: state_in = S_FIND;
                  default:            state_in = S_IDLE;
               endcase
            end
         end
         S_POP: begin
            if (stat.rsp_free) begin
               cmd.pop_done = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_FIND: begin
            cmd.find = 1'b1;
            if (stat.match) begin
               state_in = S_SHIFT;
            end else if (stat.scan_idle && stat.rsp_free) begin
               cmd.finish_nf = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SHIFT: begin
            if (stat.scan_idle && stat.rsp_free) begin
               cmd.finish_del = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.shift = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/double_ended_queue_with_delete.sv
// ----------------------------------------------------------------------------
// double_ended_queue_with_delete
// Bounded ring deque of 32-bit words with pushes, pops, delete by value, clear.
// ----------------------------------------------------------------------------
//   channel   ports                          direction  word
//   request   req_valid req_ready req_payload  in        operation, value
//   response  rsp_valid rsp_ready rsp_payload  out       status, removed_value, entry_count
//
// pushes, clear, full/empty errors and unused codes: handled in the idle state, response registered at acceptance
// pops: one registered read of the entry memory, then the response from the pop state
// delete: a search state, then a shift state moving later entries up on a match;
//   search and gap closing stream through the single read port of the entry
//   memory, one entry per cycle
// reset clears the front pointer, count and the response valid flag; memory is not cleared
// a waiting response holds off new requests until it is taken or leaving
// ----------------------------------------------------------------------------
module double_ended_queue_with_delete (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  deqd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output deqd_pkg::rsp_type rsp_payload
);

   deqd_pkg::cmd_type  cmd;
   deqd_pkg::stat_type stat;

   deqd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   deqd_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: sim/deqd_checker.sv
// ----------------------------------------------------------------------------
// deqd_checker
// Watches the request and response channels of the deque with delete. It
// keeps its own ring copy of the deque, works out the response to every
// accepted request word, and compares each accepted response word with the
// oldest outstanding one, field by field. It counts mismatches for the top.
// ----------------------------------------------------------------------------
module deqd_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  deqd_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  deqd_pkg::rsp_type rsp_payload,
   output int                fail_count,
   output int                pending,
   output int                checked,
   output int                full_seen,
   output int                empty_seen,
   output int                miss_seen
);

   logic signed [31:0] ring [deqd_pkg::DEPTH];
   int                 head;
   int                 fill;
   deqd_pkg::rsp_type  due_rsp [$];

   task automatic report(string line);
      $display("mismatch: %s", line);
      fail_count++;
   endtask

   function automatic int ring_pos(int k);
      return (head + k) % deqd_pkg::DEPTH;
   endfunction

   function automatic deqd_pkg::rsp_type deque_outcome(deqd_pkg::req_type w);
      deqd_pkg::rsp_type r;
      int                k;
      int                hit;
      r        = '0;
      r.status = deqd_pkg::ST_OK;
      case (w.operation)
         deqd_pkg::OP_PUSH_FRONT: begin
            if (fill >= deqd_pkg::DEPTH) begin
               r.status = deqd_pkg::ST_FULL;
            end else begin
               head       = (head == 0) ? deqd_pkg::DEPTH - 1 : head - 1;
               ring[head] = w.value;
               fill++;
            end
         end
         deqd_pkg::OP_PUSH_BACK: begin
            if (fill >= deqd_pkg::DEPTH) begin
               r.status = deqd_pkg::ST_FULL;
            end else begin
               ring[ring_pos(fill)] = w.value;
               fill++;
            end
         end
         deqd_pkg::OP_POP_FRONT: begin
            if (fill == 0) begin
               r.status = deqd_pkg::ST_EMPTY;
            end else begin
               r.removed_value = ring[head];
               head            = ring_pos(1);
               fill--;
            end
         end
         deqd_pkg::OP_POP_BACK: begin
            if (fill == 0) begin
               r.status = deqd_pkg::ST_EMPTY;
            end else begin
               r.removed_value = ring[ring_pos(fill - 1)];
               fill--;
            end
         end
         deqd_pkg::OP_DELETE: begin
            hit = -1;
            for (k = 0; k < fill; k++) begin
               if (hit < 0 && ring[ring_pos(k)] == w.value) begin
                  hit = k;
               end
            end
            if (hit < 0) begin
               r.status = deqd_pkg::ST_NOT_FOUND;
            end else begin
               r.removed_value = w.value;
               for (k = hit; k < fill - 1; k++) begin
                  ring[ring_pos(k)] = ring[ring_pos(k + 1)];
               end
               fill--;
            end
         end
         deqd_pkg::OP_CLEAR: begin
            fill = 0;
            head = 0;
         end
         default: begin
         end
      endcase
      r.entry_count = 5'(fill);
      return r;
   endfunction

   always @(posedge clock) begin
      deqd_pkg::rsp_type want;
      if (reset) begin
         head       = 0;
         fill       = 0;
         due_rsp.delete();
         fail_count = 0;
         pending    = 0;
         checked    = 0;
         full_seen  = 0;
         empty_seen = 0;
         miss_seen  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_rsp.size() == 0) begin
               report($sformatf("response word %0h with nothing outstanding", rsp_payload));
            end else begin
               want = due_rsp.pop_front();
               if (rsp_payload.status !== want.status) begin
                  report($sformatf("word %0d status %0d, expected %0d",
                                   checked, rsp_payload.status, want.status));
               end
               if (rsp_payload.removed_value !== want.removed_value) begin
                  report($sformatf("word %0d removed_value %0h, expected %0h",
                                   checked, rsp_payload.removed_value, want.removed_value));
               end
               if (rsp_payload.entry_count !== want.entry_count) begin
                  report($sformatf("word %0d entry_count %0d, expected %0d",
                                   checked, rsp_payload.entry_count, want.entry_count));
               end
               case (want.status)
                  deqd_pkg::ST_FULL:      full_seen++;
                  deqd_pkg::ST_EMPTY:     empty_seen++;
                  deqd_pkg::ST_NOT_FOUND: miss_seen++;
                  default: begin
                  end
               endcase
               checked++;
            end
         end
         if (req_valid && req_ready) begin
            due_rsp.push_back(deque_outcome(req_payload));
         end
         pending = due_rsp.size();
      end
   end

endmodule

FILE: sim/tb_double_ended_queue_with_delete.sv
// ----------------------------------------------------------------------------
// tb_double_ended_queue_with_delete
// Drives request words into the deque with delete: a short directed run over
// the empty, wrap, delete and unused-code cases, then phases of random words
// that fill, drain or mix the deque, with random idling on both channels.
// The checker beside the block predicts and compares every response word.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_with_delete;

   localparam logic [2:0] OP_SPARE_A  = 3'd6;
   localparam logic [2:0] OP_SPARE_B  = 3'd7;
   localparam int         RANDOM_WORDS = 950;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   deqd_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   deqd_pkg::rsp_type rsp_payload;

   int fail_count;
   int pending;
   int checked;
   int full_seen;
   int empty_seen;
   int miss_seen;

   int                 sent;
   bit                 calm;
   logic signed [31:0] pushed_vals [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   double_ended_queue_with_delete u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   deqd_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .pending     (pending),
      .checked     (checked),
      .full_seen   (full_seen),
      .empty_seen  (empty_seen),
      .miss_seen   (miss_seen)
   );

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end else if (roll < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   task automatic send_word(logic [2:0] op, logic signed [31:0] v);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_payload.operation <= op;
      req_payload.value     <= v;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   // response side: random stalls, one word taken per ready stretch
   initial begin
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int                 mode;
      int                 length;
      int                 push_pct;
      int                 roll;
      int                 pick;
      logic [2:0]         op;
      logic signed [31:0] v;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_ready   = 1'b0;
      sent        = 0;
      calm        = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty deque, pushes from both ends across the ring wrap, deletes
      send_word(deqd_pkg::OP_POP_FRONT, 32'sd0);
      send_word(deqd_pkg::OP_POP_BACK, 32'sd0);
      send_word(deqd_pkg::OP_DELETE, 32'sd7);
      send_word(deqd_pkg::OP_PUSH_FRONT, 32'sh7fff_ffff);
      send_word(deqd_pkg::OP_PUSH_BACK, 32'sh8000_0000);
      send_word(deqd_pkg::OP_PUSH_BACK, 32'sd0);
      send_word(deqd_pkg::OP_PUSH_FRONT, -32'sd1);
      send_word(deqd_pkg::OP_DELETE, 32'sh8000_0000);
      send_word(deqd_pkg::OP_DELETE, 32'sd12345);
      send_word(OP_SPARE_A, 32'sh5a5a_a5a5);
      send_word(OP_SPARE_B, -32'sd1);
      send_word(deqd_pkg::OP_POP_FRONT, 32'sd0);
      send_word(deqd_pkg::OP_POP_BACK, 32'sd0);
      send_word(deqd_pkg::OP_DELETE, 32'sh7fff_ffff);
      send_word(deqd_pkg::OP_PUSH_BACK, 32'sd9);
      send_word(deqd_pkg::OP_CLEAR, 32'sd9);
      send_word(deqd_pkg::OP_POP_FRONT, 32'sd0);

      // random phases: fill-heavy, drain-heavy or mixed
      while (sent < RANDOM_WORDS + 17) begin
         mode     = $urandom_range(0, 2);
         calm     = ($urandom_range(0, 3) == 0);
         length   = $urandom_range(20, 60);
         push_pct = (mode == 0) ? 80 : (mode == 1) ? 15 : 45;
         while (length > 0 && sent < RANDOM_WORDS + 17) begin
            length--;
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
               op = deqd_pkg::OP_CLEAR;
            end else if (roll < 3) begin
               op = $urandom_range(0, 1) ? OP_SPARE_B : OP_SPARE_A;
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < push_pct) begin
                  op = $urandom_range(0, 1) ? deqd_pkg::OP_PUSH_BACK
                                            : deqd_pkg::OP_PUSH_FRONT;
               end else if (roll < push_pct + (100 - push_pct) * 2 / 3) begin
                  op = $urandom_range(0, 1) ? deqd_pkg::OP_POP_BACK
                                            : deqd_pkg::OP_POP_FRONT;
               end else begin
                  op = deqd_pkg::OP_DELETE;
               end
            end
            roll = $urandom_range(0, 9);
            if (op == deqd_pkg::OP_DELETE && roll < 7 && pushed_vals.size() > 0) begin
               v = pushed_vals[$urandom_range(0, pushed_vals.size() - 1)];
            end else if (roll < 2) begin
               pick = $urandom_range(0, 3);
               v = (pick == 0) ? 32'sh8000_0000 : (pick == 1) ? 32'sh7fff_ffff :
                   (pick == 2) ? 32'sd0 : -32'sd1;
            end else if (roll < 5) begin
               v = 32'($urandom_range(0, 7)) - 32'sd4;
            end else begin
               v = $urandom;
            end
            if (op == deqd_pkg::OP_PUSH_FRONT || op == deqd_pkg::OP_PUSH_BACK) begin
               pushed_vals.push_back(v);
               if (pushed_vals.size() > 32) begin
                  void'(pushed_vals.pop_front());
               end
            end
            send_word(op, v);
         end
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      @(posedge clock);
      wait (pending == 0);
      repeat (40) @(posedge clock);
      $display("%0d request words sent, %0d response words compared", sent, checked);
      $display("full %0d, empty %0d, not found %0d among them",
               full_seen, empty_seen, miss_seen);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
